@@ sv/ssig_pkg.sv @@
package ssig_pkg;

    // Sizes of the index store and of the fields.
    localparam int MAX_ROWS   = 64;
    localparam int ROW_W      = 7;
    localparam int IDX_W      = 6;
    localparam int RATIO_W    = 16;
    localparam int SEED_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int MOD_CNT_W  = 5;

    // Linear congruential generator constants.
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RATIO    = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_LCG,
        ST_MSTART,
        ST_MWAIT,
        ST_RD,
        ST_WR1,
        ST_WR2,
        ST_OUTRD,
        ST_EMIT
    } t_state;

    // Control from the sequencer to the modulo unit.
    typedef struct packed {
        logic              start;
        logic [SEED_W-1:0] dividend;
        logic [ROW_W-1:0]  divisor;
    } t_mod_ctl;

    // Status from the modulo unit back to the sequencer.
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] remainder;
    } t_mod_sts;

endpackage

@@ sv/ssig_req_if.sv @@
interface ssig_req_if;
    logic                           valid;
    logic                           ready;
    logic [ssig_pkg::ROW_W-1:0]     feature_rows;
    logic [ssig_pkg::ROW_W-1:0]     target_rows;
    logic [ssig_pkg::RATIO_W-1:0]   holdout_ratio;
    logic [ssig_pkg::SEED_W-1:0]    seed;

    modport source (
        output valid, feature_rows, target_rows, holdout_ratio, seed,
        input  ready
    );
    modport sink (
        input  valid, feature_rows, target_rows, holdout_ratio, seed,
        output ready
    );
endinterface

@@ sv/ssig_res_if.sv @@
interface ssig_res_if;
    logic                           valid;
    logic                           ready;
    logic [ssig_pkg::IDX_W-1:0]     source_row;
    logic                           in_test;
    logic [ssig_pkg::IDX_W-1:0]     set_position;
    logic                           row_valid;
    logic                           last;
    logic [ssig_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid, source_row, in_test, set_position, row_valid, last, status,
        input  ready
    );
    modport sink (
        input  valid, source_row, in_test, set_position, row_valid, last, status,
        output ready
    );
endinterface

@@ sv/ssig_mod_unit.sv @@
// Serial restoring modulo: a 32-bit dividend by a divisor of at most MAX_ROWS,
// one quotient bit per cycle. The remainder is valid when done pulses.
module ssig_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssig_pkg::t_mod_ctl i_ctl,
    output ssig_pkg::t_mod_sts o_sts
);

    logic                              r_busy;
    logic                              r_done;
    logic [ssig_pkg::MOD_CNT_W-1:0]    r_cnt;
    logic [ssig_pkg::SEED_W-1:0]       r_dvd;
    logic [ssig_pkg::ROW_W-1:0]        r_div;
    logic [ssig_pkg::IDX_W-1:0]        r_rem;
    logic [ssig_pkg::ROW_W-1:0]        n_trial;
    logic [ssig_pkg::ROW_W-1:0]        n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        n_trial = {r_rem, r_dvd[ssig_pkg::SEED_W-1]};
        if (n_trial >= r_div) begin
            n_rem = n_trial - r_div;
        end else begin
            n_rem = n_trial;
        end
    end

    // Control: busy for one step per dividend bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: the partial remainder stays below the divisor, so six bits hold it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_ctl.dividend;
            r_div <= i_ctl.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ssig_pkg::SEED_W-2:0], 1'b0};
            r_rem <= n_rem[ssig_pkg::IDX_W-1:0];
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.remainder = r_rem;

endmodule

@@ sv/shuffled_split_index_generator_unit.sv @@
// Shuffled split index generator. Each request transaction carries feature and
// target row counts, a Q0.16 test ratio and a 32-bit seed. After a check of the
// request the block writes the identity permutation into a 64-entry index
// store, shuffles it downward Fisher-Yates style with j = lcg(seed) mod i, and
// then sends one result transaction per row, training rows first and test rows
// after, each tagged with its set and its position in that set; the test count
// is floor(rows * ratio / 65536). A count mismatch or a zero ratio gives one
// status-only result, and zero rows gives one empty result with status ok.
// The block takes one request at a time and is not ready while it works. A
// request of n rows is worked as a fill of the store, then one shuffle step for
// each i from n down to two, each waiting on the bit-serial modulo unit, then
// for each result a store read and a load of the output register. Error and
// empty requests skip the store.
module shuffled_split_index_generator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssig_req_if.sink   i_req,
    ssig_res_if.source o_res
);

    ssig_pkg::t_state                  r_state;
    ssig_pkg::t_state                  n_state;

    // Request registers.
    logic [ssig_pkg::ROW_W-1:0]        r_frows;
    logic [ssig_pkg::ROW_W-1:0]        r_trows;
    logic [ssig_pkg::RATIO_W-1:0]      r_ratio;
    logic [ssig_pkg::SEED_W-1:0]       r_gen;
    logic [ssig_pkg::ROW_W-1:0]        r_rows;
    logic [ssig_pkg::ROW_W-1:0]        r_test_n;

    // Loop registers.
    logic [ssig_pkg::IDX_W-1:0]        r_idx;
    logic [ssig_pkg::ROW_W-1:0]        r_i;
    logic [ssig_pkg::IDX_W-1:0]        r_j;

    // Index store with two registered read ports and one write port.
    logic [ssig_pkg::IDX_W-1:0]        r_mem [ssig_pkg::MAX_ROWS];
    logic [ssig_pkg::IDX_W-1:0]        r_rd_a;
    logic [ssig_pkg::IDX_W-1:0]        r_rd_b;
    logic                              mem_we;
    logic [ssig_pkg::IDX_W-1:0]        mem_waddr;
    logic [ssig_pkg::IDX_W-1:0]        mem_wdata;
    logic [ssig_pkg::IDX_W-1:0]        mem_raddr_a;
    logic [ssig_pkg::IDX_W-1:0]        mem_raddr_b;

    // Output register.
    logic                              r_out_valid;
    logic [ssig_pkg::IDX_W-1:0]        r_out_src;
    logic                              r_out_test;
    logic [ssig_pkg::IDX_W-1:0]        r_out_pos;
    logic                              r_out_rowv;
    logic                              r_out_last;
    logic [ssig_pkg::STATUS_W-1:0]     r_out_status;

    // Modulo unit link.
    ssig_pkg::t_mod_ctl                mod_ctl;
    ssig_pkg::t_mod_sts                mod_sts;

    // Helper signals.
    logic                              in_accept;
    logic                              slot_free;
    logic                              req_special;
    logic [ssig_pkg::STATUS_W-1:0]     special_status;
    logic [ssig_pkg::ROW_W-1:0]        sat_rows;
    logic [ssig_pkg::ROW_W+ssig_pkg::RATIO_W-1:0] test_prod;
    logic [ssig_pkg::ROW_W-1:0]        i_minus_1;
    logic [ssig_pkg::ROW_W-1:0]        train_n;
    logic                              emit_test;
    logic                              emit_last;
    logic                              fill_last;
    logic                              out_load;
    logic [ssig_pkg::IDX_W-1:0]        out_src;
    logic                              out_test;
    logic [ssig_pkg::IDX_W-1:0]        out_pos;
    logic                              out_rowv;
    logic                              out_last;
    logic [ssig_pkg::STATUS_W-1:0]     out_status;

    assign in_accept = i_req.valid && i_req.ready;
    assign slot_free = !r_out_valid || o_res.ready;

    // Request classification and derived counts.
    assign sat_rows  = (r_frows > ssig_pkg::ROW_W'(ssig_pkg::MAX_ROWS))
                     ? ssig_pkg::ROW_W'(ssig_pkg::MAX_ROWS) : r_frows;
    assign req_special = (r_frows != r_trows) || (r_ratio == '0) || (r_frows == '0);
    always_comb begin
        if (r_frows != r_trows) begin
            special_status = ssig_pkg::STATUS_MISMATCH;
        end else if (r_ratio == '0) begin
            special_status = ssig_pkg::STATUS_RATIO;
        end else begin
            special_status = ssig_pkg::STATUS_OK;
        end
    end
    assign test_prod = (ssig_pkg::ROW_W+ssig_pkg::RATIO_W)'(sat_rows)
                     * (ssig_pkg::ROW_W+ssig_pkg::RATIO_W)'(r_ratio);
    assign i_minus_1 = r_i - 1'b1;
    assign train_n   = r_rows - r_test_n;
    assign fill_last = ({1'b0, r_idx} == (r_rows - 1'b1));
    assign emit_test = ({1'b0, r_idx} >= train_n);
    assign emit_last = fill_last;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssig_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = ssig_pkg::ST_CHECK;
                end
            end
            ssig_pkg::ST_CHECK: begin
                if (req_special) begin
                    if (slot_free) begin
                        n_state = ssig_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = ssig_pkg::ST_FILL;
                end
            end
            ssig_pkg::ST_FILL: begin
                if (fill_last) begin
                    if (r_rows > ssig_pkg::ROW_W'(1)) begin
                        n_state = ssig_pkg::ST_LCG;
                    end else begin
                        n_state = ssig_pkg::ST_OUTRD;
                    end
                end
            end
            ssig_pkg::ST_LCG:    n_state = ssig_pkg::ST_MSTART;
            ssig_pkg::ST_MSTART: n_state = ssig_pkg::ST_MWAIT;
            ssig_pkg::ST_MWAIT: begin
                if (mod_sts.done) begin
                    n_state = ssig_pkg::ST_RD;
                end
            end
            ssig_pkg::ST_RD:  n_state = ssig_pkg::ST_WR1;
            ssig_pkg::ST_WR1: n_state = ssig_pkg::ST_WR2;
            ssig_pkg::ST_WR2: begin
                if (i_minus_1 > ssig_pkg::ROW_W'(1)) begin
                    n_state = ssig_pkg::ST_LCG;
                end else begin
                    n_state = ssig_pkg::ST_OUTRD;
                end
            end
            ssig_pkg::ST_OUTRD: n_state = ssig_pkg::ST_EMIT;
            ssig_pkg::ST_EMIT: begin
                if (slot_free) begin
                    if (emit_last) begin
                        n_state = ssig_pkg::ST_IDLE;
                    end else begin
                        n_state = ssig_pkg::ST_OUTRD;
                    end
                end
            end
            default: n_state = ssig_pkg::ST_IDLE;
        endcase
    end

    // Output logic of the sequencer: store ports, modulo start, result load.
    always_comb begin
        i_req.ready      = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = r_idx;
        mem_wdata        = r_idx;
        mem_raddr_a      = i_minus_1[ssig_pkg::IDX_W-1:0];
        mem_raddr_b      = r_j;
        mod_ctl.start    = 1'b0;
        mod_ctl.dividend = r_gen;
        mod_ctl.divisor  = r_i;
        out_load         = 1'b0;
        out_src          = '0;
        out_test         = 1'b0;
        out_pos          = '0;
        out_rowv         = 1'b0;
        out_last         = 1'b1;
        out_status       = special_status;
        case (r_state)
            ssig_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ssig_pkg::ST_CHECK: begin
                out_load = req_special && slot_free;
            end
            ssig_pkg::ST_FILL: begin
                mem_we = 1'b1;
            end
            ssig_pkg::ST_MSTART: begin
                mod_ctl.start = 1'b1;
            end
            ssig_pkg::ST_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = i_minus_1[ssig_pkg::IDX_W-1:0];
                mem_wdata = r_rd_b;
            end
            ssig_pkg::ST_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_rd_a;
            end
            ssig_pkg::ST_OUTRD: begin
                mem_raddr_a = r_idx;
            end
            ssig_pkg::ST_EMIT: begin
                // Keep reading the same entry while the result waits.
                mem_raddr_a = r_idx;
                out_load   = slot_free;
                out_src    = r_rd_a;
                out_test   = emit_test;
                out_pos    = emit_test ? (r_idx - train_n[ssig_pkg::IDX_W-1:0]) : r_idx;
                out_rowv   = 1'b1;
                out_last   = emit_last;
                out_status = ssig_pkg::STATUS_OK;
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssig_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture, generator advance and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= '0;
        end else begin
            case (r_state)
                ssig_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_frows <= i_req.feature_rows;
                        r_trows <= i_req.target_rows;
                        r_ratio <= i_req.holdout_ratio;
                        r_gen   <= i_req.seed;
                    end
                end
                ssig_pkg::ST_CHECK: begin
                    r_rows   <= sat_rows;
                    r_test_n <= test_prod[ssig_pkg::ROW_W+ssig_pkg::RATIO_W-1:ssig_pkg::RATIO_W];
                    r_idx    <= '0;
                    r_i      <= sat_rows;
                end
                ssig_pkg::ST_FILL: begin
                    if (fill_last) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ssig_pkg::ST_LCG: begin
                    r_gen <= r_gen * ssig_pkg::LCG_MUL + ssig_pkg::LCG_ADD;
                end
                ssig_pkg::ST_MWAIT: begin
                    if (mod_sts.done) begin
                        r_j <= mod_sts.remainder;
                    end
                end
                ssig_pkg::ST_WR2: begin
                    r_i <= i_minus_1;
                end
                ssig_pkg::ST_EMIT: begin
                    if (slot_free) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_gen <= r_gen;
                end
            endcase
        end
    end

    // Index store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_mem[mem_raddr_a];
        r_rd_b <= r_mem[mem_raddr_b];
    end

    // Output register: holds a result until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_src    <= out_src;
            r_out_test   <= out_test;
            r_out_pos    <= out_pos;
            r_out_rowv   <= out_rowv;
            r_out_last   <= out_last;
            r_out_status <= out_status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.source_row   = r_out_src;
    assign o_res.in_test      = r_out_test;
    assign o_res.set_position = r_out_pos;
    assign o_res.row_valid    = r_out_rowv;
    assign o_res.last         = r_out_last;
    assign o_res.status       = r_out_status;

    // Serial modulo unit of the shuffle steps.
    ssig_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mod_ctl),
        .o_sts   (mod_sts)
    );

endmodule

@@ bench/tb_top.sv @@
module tb_top;

    // One request transaction as the bench sees it.
    typedef struct packed {
        logic [ssig_pkg::ROW_W-1:0]   feature_rows;
        logic [ssig_pkg::ROW_W-1:0]   target_rows;
        logic [ssig_pkg::RATIO_W-1:0] holdout_ratio;
        logic [ssig_pkg::SEED_W-1:0]  seed;
    } t_split_req;

    // One result transaction: a shuffled row or a status-only word.
    typedef struct packed {
        logic [ssig_pkg::IDX_W-1:0]    source_row;
        logic                          in_test;
        logic [ssig_pkg::IDX_W-1:0]    set_position;
        logic                          row_valid;
        logic                          last;
        logic [ssig_pkg::STATUS_W-1:0] status;
    } t_split_row;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk;
    logic i_rst_n;

    ssig_req_if req_if();
    ssig_res_if res_if();

    shuffled_split_index_generator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_split_row expected_rows_q[$];
    int error_count = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Prints one line per error and counts them all.
    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic string fmt_row(input t_split_row r);
        return $sformatf("src=%0d test=%0d pos=%0d rv=%0d last=%0d st=%0d",
                         r.source_row, r.in_test, r.set_position, r.row_valid,
                         r.last, r.status);
    endfunction

    function automatic t_split_req make_req(input int frows, input int trows,
                                            input int ratio, input logic [31:0] seed);
        t_split_req r;
        r.feature_rows  = ssig_pkg::ROW_W'(frows);
        r.target_rows   = ssig_pkg::ROW_W'(trows);
        r.holdout_ratio = ssig_pkg::RATIO_W'(ratio);
        r.seed          = seed;
        return r;
    endfunction

    // Works out the shuffled split for one request and queues its rows.
    function automatic void predict_split(input t_split_req r);
        logic [ssig_pkg::IDX_W-1:0]  perm [ssig_pkg::MAX_ROWS];
        logic [ssig_pkg::SEED_W-1:0] lcg;
        logic [ssig_pkg::IDX_W-1:0]  tmp;
        int rows;
        int test_cnt;
        int train_cnt;
        int j;
        t_split_row e;
        e = '0;
        e.last = 1'b1;
        lcg = r.seed;
        if (r.feature_rows != r.target_rows) begin
            e.status = ssig_pkg::STATUS_MISMATCH;
            expected_rows_q.push_back(e);
            return;
        end
        if (r.holdout_ratio == '0) begin
            e.status = ssig_pkg::STATUS_RATIO;
            expected_rows_q.push_back(e);
            return;
        end
        rows = (int'(r.feature_rows) > ssig_pkg::MAX_ROWS) ? ssig_pkg::MAX_ROWS
                                                            : int'(r.feature_rows);
        if (rows == 0) begin
            e.status = ssig_pkg::STATUS_OK;
            expected_rows_q.push_back(e);
            return;
        end
        for (int i = 0; i < rows; i++) begin
            perm[i] = ssig_pkg::IDX_W'(i);
        end
        // Downward Fisher-Yates pass driven by the generator.
        for (int i = rows; i > 1; i--) begin
            lcg = lcg * ssig_pkg::LCG_MUL + ssig_pkg::LCG_ADD;
            j = int'(lcg % ssig_pkg::SEED_W'(i));
            tmp = perm[i-1];
            perm[i-1] = perm[j];
            perm[j] = tmp;
        end
        test_cnt = (rows * int'(r.holdout_ratio)) >> 16;
        train_cnt = rows - test_cnt;
        for (int i = 0; i < rows; i++) begin
            e.source_row   = perm[i];
            e.in_test      = (i >= train_cnt);
            e.set_position = ssig_pkg::IDX_W'(e.in_test ? i - train_cnt : i);
            e.row_valid    = 1'b1;
            e.last         = (i == rows - 1);
            e.status       = ssig_pkg::STATUS_OK;
            expected_rows_q.push_back(e);
        end
    endfunction

    // Drives one request after a random gap and waits for its acceptance.
    task automatic send_request(input t_split_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.feature_rows  <= r.feature_rows;
        req_if.target_rows   <= r.target_rows;
        req_if.holdout_ratio <= r.holdout_ratio;
        req_if.seed          <= r.seed;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Random request, mostly well formed with a bias toward small row counts.
    function automatic t_split_req random_request();
        t_split_req r;
        int kind;
        int pick;
        int rows;
        int other;
        kind = $urandom_range(99);
        pick = $urandom_range(99);
        if (pick < 70) rows = $urandom_range(12, 1);
        else if (pick < 88) rows = $urandom_range(40, 13);
        else if (pick < 96) rows = $urandom_range(64, 41);
        else rows = $urandom_range(127, 65);
        r = make_req(rows, rows, $urandom_range(65535, 1), $urandom);
        if (kind >= 80 && kind < 88) begin
            // Count mismatch over the full 7-bit range.
            r.feature_rows = ssig_pkg::ROW_W'($urandom_range(127));
            other = $urandom_range(127);
            if (ssig_pkg::ROW_W'(other) == r.feature_rows) other = other ^ 1;
            r.target_rows = ssig_pkg::ROW_W'(other);
            r.holdout_ratio = ssig_pkg::RATIO_W'($urandom_range(65535));
        end else if (kind >= 88 && kind < 94) begin
            r.holdout_ratio = '0;
        end else if (kind >= 94) begin
            r.feature_rows = '0;
            r.target_rows  = '0;
        end else if (pick < 30) begin
            // Push the ratio toward both ends of its range.
            r.holdout_ratio = ssig_pkg::RATIO_W'(($urandom_range(1))
                                                 ? $urandom_range(255, 1)
                                                 : $urandom_range(65535, 65280));
        end
        return r;
    endfunction

    // Status-only answers: count mismatch, zero ratio and zero rows.
    task automatic test_status_requests();
        send_request(make_req(5, 6, 16'h8000, 32'h0000_0001));
        send_request(make_req(127, 0, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(64, 100, 16'h4000, 32'h1234_5678));
        send_request(make_req(3, 4, 0, 32'h0));
        send_request(make_req(10, 10, 0, 32'hDEAD_BEEF));
        send_request(make_req(0, 0, 0, 32'h0));
        send_request(make_req(0, 0, 16'h4000, 32'h5555_5555));
        send_request(make_req(0, 0, 16'hFFFF, 32'hAAAA_AAAA));
    endtask

    // Extremes of the row count and of the ratio, saturation included.
    task automatic test_split_extremes();
        send_request(make_req(1, 1, 1, 32'h0));
        send_request(make_req(1, 1, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(2, 2, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(2, 2, 16'h8000, 32'h0));
        send_request(make_req(64, 64, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(64, 64, 1, 32'h0));
        send_request(make_req(65, 65, 16'h8000, 32'h8000_0000));
        send_request(make_req(127, 127, 16'h5555, 32'hAAAA_AAAA));
        send_request(make_req(100, 100, 16'hAAAA, 32'h5555_5555));
        send_request(make_req(7, 7, 16'h2AAA, 32'h1234_5678));
        send_request(make_req(63, 63, 16'h0400, 32'h0F0F_0F0F));
    endtask

    task automatic test_random_splits(input int count, input int src_pct,
                                      input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        repeat (count) send_request(random_request());
    endtask

    // Receiver side: random back-pressure on the result channel.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Every accepted request feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_split({req_if.feature_rows, req_if.target_rows,
                           req_if.holdout_ratio, req_if.seed});
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge i_clk) begin : res_check
        t_split_row got;
        t_split_row want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.source_row, res_if.in_test, res_if.set_position,
                   res_if.row_valid, res_if.last, res_if.status};
            if (expected_rows_q.size() == 0) begin
                report_error({"unexpected result: ", fmt_row(got)});
            end else begin
                want = expected_rows_q.pop_front();
                if (got !== want) begin
                    report_error({"got ", fmt_row(got), " expected ", fmt_row(want)});
                end
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.feature_rows = '0;
        req_if.target_rows = '0;
        req_if.holdout_ratio = '0;
        req_if.seed = '0;
        res_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_status_requests();
        test_split_extremes();
        test_random_splits(63, 0, 0);
        test_random_splits(63, 47, 0);
        test_random_splits(63, 0, 47);
        test_random_splits(63, 23, 23);
        req_if.valid <= 1'b0;

        // Let the predictor see the last request before the queue is watched.
        @(posedge i_clk);

        // Drain outstanding results, then watch for stray ones.
        while (expected_rows_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_rows_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
